// ===== rtl/core/dq_pkg.sv =====
// shared types and constants for the double-ended queue
package dq_pkg;

    localparam int CAPACITY = 16;
    localparam int DATA_W   = 8;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_REAR  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_REAR   = 3'd3,
        OP_CLEAR      = 3'd4
    } opcode_t;

    typedef enum logic [1:0] {
        ST_DONE        = 2'd0,
        ST_PUSH_REJECT = 2'd1,
        ST_POP_REJECT  = 2'd2
    } status_t;

    // command broadcast to every cell in the row
    typedef enum logic [2:0] {
        CMD_HOLD       = 3'd0,
        CMD_SHIFT_IN   = 3'd1,
        CMD_APPEND     = 3'd2,
        CMD_SHIFT_OUT  = 3'd3,
        CMD_DROP_LAST  = 3'd4,
        CMD_CLEAR      = 3'd5
    } cell_cmd_t;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic              valid;
        logic [DATA_W-1:0] data_next;
        logic              valid_next;
        logic              last_now;
        logic              last_next;
    } cell_out_t;

endpackage

// ===== rtl/core/dq_cell.sv =====
// one storage cell of the queue row, shifting data with its neighbors
module dq_cell
    import dq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cell_cmd_t         cmd,
    input  logic [DATA_W-1:0] push_value,
    input  logic [DATA_W-1:0] left_data,
    input  logic              left_valid,
    input  logic [DATA_W-1:0] right_data,
    input  logic              right_valid,
    input  logic              right_valid_next,
    output cell_out_t         status
);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;
    logic              valid_reg;
    logic              valid_next;

    always_comb
    begin
        data_next  = data_reg;
        valid_next = valid_reg;
        case (cmd)
            CMD_SHIFT_IN:
            begin
                data_next  = left_data;
                valid_next = left_valid;
            end
            CMD_APPEND:
            begin
                // first empty cell behind the occupied run takes the byte
                if (!valid_reg && left_valid)
                begin
                    data_next  = push_value;
                    valid_next = 1'b1;
                end
            end
            CMD_SHIFT_OUT:
            begin
                data_next  = right_data;
                valid_next = right_valid;
            end
            CMD_DROP_LAST:
            begin
                valid_next = valid_reg & right_valid;
            end
            CMD_CLEAR:
            begin
                valid_next = 1'b0;
            end
            default:
            begin
                data_next  = data_reg;
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign status.data       = data_reg;
    assign status.valid      = valid_reg;
    assign status.data_next  = data_next;
    assign status.valid_next = valid_next;
    assign status.last_now   = valid_reg & ~right_valid;
    assign status.last_next  = valid_next & ~right_valid_next;

endmodule

// ===== rtl/core/double_ended_queue.sv =====
// bounded double-ended queue built as a row of shifting byte cells
// latency: result is presented the cycle after the transaction is accepted
// throughput: one operation per cycle unless an unread result holds in_ready low; every cell updates in the same cycle
// a new operation is taken while the previous result is being taken
// reset: asynchronous active low, empties the queue and clears out_valid
// cell contents are not reset and are only read behind their valid bits
module double_ended_queue
    import dq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [2:0]        opcode,
    input  logic [DATA_W-1:0] push_value,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] popped_value,
    output logic [DATA_W-1:0] front_value,
    output logic [DATA_W-1:0] rear_value,
    output logic [CNT_W-1:0]  occupancy,
    output logic              full_flag,
    output logic              empty_flag,
    output logic [1:0]        op_status
);

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    cell_out_t          cells [CAPACITY];
    cell_cmd_t          cmd;
    logic               accept;
    logic               is_full;
    logic               no_entries;
    status_t            status_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic [DATA_W-1:0]  popped_next;
    logic [DATA_W-1:0]  rear_now;
    logic [DATA_W-1:0]  rear_next;
    logic [DATA_W-1:0]  front_next;

    logic               out_valid_reg;
    logic [DATA_W-1:0]  popped_reg;
    logic [DATA_W-1:0]  front_reg;
    logic [DATA_W-1:0]  rear_reg;
    logic [CNT_W-1:0]   occ_reg;
    logic               full_reg;
    logic               empty_reg;
    status_t            status_reg;

    assign in_ready   = ~out_valid_reg | out_ready;
    assign accept     = in_valid & in_ready;
    assign is_full    = (cnt_reg == CAP_CNT);
    assign no_entries = (cnt_reg == '0);

    // rear entry is the valid cell whose right neighbor is empty
    always_comb
    begin
        rear_now  = '0;
        rear_next = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            rear_now  = rear_now  | (cells[i].last_now  ? cells[i].data      : '0);
            rear_next = rear_next | (cells[i].last_next ? cells[i].data_next : '0);
        end
    end

    always_comb
    begin
        cmd         = CMD_HOLD;
        status_next = ST_DONE;
        cnt_next    = cnt_reg;
        popped_next = '0;
        if (accept)
        begin
            case (opcode)
                OP_PUSH_FRONT:
                begin
                    if (is_full)
                        status_next = ST_PUSH_REJECT;
                    else
                    begin
                        cmd      = CMD_SHIFT_IN;
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
                OP_PUSH_REAR:
                begin
                    if (is_full)
                        status_next = ST_PUSH_REJECT;
                    else
                    begin
                        cmd      = CMD_APPEND;
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
                OP_POP_FRONT:
                begin
                    if (no_entries)
                        status_next = ST_POP_REJECT;
                    else
                    begin
                        cmd         = CMD_SHIFT_OUT;
                        cnt_next    = cnt_reg - 1'b1;
                        popped_next = cells[0].data;
                    end
                end
                OP_POP_REAR:
                begin
                    if (no_entries)
                        status_next = ST_POP_REJECT;
                    else
                    begin
                        cmd         = CMD_DROP_LAST;
                        cnt_next    = cnt_reg - 1'b1;
                        popped_next = rear_now;
                    end
                end
                OP_CLEAR:
                begin
                    cmd      = CMD_CLEAR;
                    cnt_next = '0;
                end
                default:
                begin
                    cmd = CMD_HOLD;
                end
            endcase
        end
    end

    assign front_next = cells[0].valid_next ? cells[0].data_next : '0;

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic [DATA_W-1:0] left_data;
        logic              left_valid;
        logic [DATA_W-1:0] right_data;
        logic              right_valid;
        logic              right_valid_next;

        // the head of the row sees the pushed byte as its left neighbor
        if (g == 0)
        begin : g_head
            assign left_data  = push_value;
            assign left_valid = 1'b1;
        end
        else
        begin : g_body
            assign left_data  = cells[g-1].data;
            assign left_valid = cells[g-1].valid;
        end

        if (g == CAPACITY - 1)
        begin : g_tail
            assign right_data       = '0;
            assign right_valid      = 1'b0;
            assign right_valid_next = 1'b0;
        end
        else
        begin : g_inner
            assign right_data       = cells[g+1].data;
            assign right_valid      = cells[g+1].valid;
            assign right_valid_next = cells[g+1].valid_next;
        end

        dq_cell u_cell (
            .clk              (clk),
            .rst_n            (rst_n),
            .cmd              (cmd),
            .push_value       (push_value),
            .left_data        (left_data),
            .left_valid       (left_valid),
            .right_data       (right_data),
            .right_valid      (right_valid),
            .right_valid_next (right_valid_next),
            .status           (cells[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (accept)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            popped_reg <= popped_next;
            front_reg  <= front_next;
            rear_reg   <= rear_next;
            occ_reg    <= cnt_next;
            full_reg   <= (cnt_next == CAP_CNT);
            empty_reg  <= (cnt_next == '0);
            status_reg <= status_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign popped_value = popped_reg;
    assign front_value  = front_reg;
    assign rear_value   = rear_reg;
    assign occupancy    = occ_reg;
    assign full_flag    = full_reg;
    assign empty_flag   = empty_reg;
    assign op_status    = status_reg;

endmodule

// ===== rtl/core/dq_checker.sv =====
// port-level checks for the double-ended queue, bound to the top level
module dq_checker
    import dq_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_ready,
    input logic [DATA_W-1:0] popped_value,
    input logic [DATA_W-1:0] front_value,
    input logic [DATA_W-1:0] rear_value,
    input logic [CNT_W-1:0]  occupancy,
    input logic              full_flag,
    input logic              empty_flag,
    input logic [1:0]        op_status
);

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    a_flags_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (full_flag == (occupancy == CAP_CNT))
                   && (empty_flag == (occupancy == '0)))
        else $error("full or empty flag disagrees with occupancy");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && empty_flag |-> (front_value == '0) && (rear_value == '0))
        else $error("empty queue shows nonzero front or rear");

    a_reject_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (op_status == ST_PUSH_REJECT || op_status == ST_POP_REJECT)
            |-> (popped_value == '0))
        else $error("rejected transaction reports a popped value");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(occupancy)
            && $stable(front_value) && $stable(op_status))
        else $error("stalled result changed");

endmodule

bind double_ended_queue dq_checker u_dq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .popped_value (popped_value),
    .front_value  (front_value),
    .rear_value   (rear_value),
    .occupancy    (occupancy),
    .full_flag    (full_flag),
    .empty_flag   (empty_flag),
    .op_status    (op_status)
);

// ===== tb/testbench.sv =====
// testbench for the double-ended queue: directed and random operations checked by a shadow deque
`timescale 1ns / 1ps

module testbench;
    import dq_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int PRINT_LIMIT = 30;

    typedef struct {
        logic [DATA_W-1:0] popped;
        logic [DATA_W-1:0] front;
        logic [DATA_W-1:0] rear;
        logic [CNT_W-1:0]  count;
        logic              full;
        logic              empty;
        status_t           status;
    } deque_view_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [2:0]        opcode;
    logic [DATA_W-1:0] push_value;
    logic              out_valid;
    logic              out_ready;
    logic [DATA_W-1:0] popped_value;
    logic [DATA_W-1:0] front_value;
    logic [DATA_W-1:0] rear_value;
    logic [CNT_W-1:0]  occupancy;
    logic              full_flag;
    logic              empty_flag;
    logic [1:0]        op_status;

    // shadow copy of the queue contents
    logic [DATA_W-1:0] shadow_store [CAPACITY];
    int                shadow_head  = 0;
    int                shadow_count = 0;

    deque_view_t pending_views[$];

    int  mismatch_count = 0;
    int  results_seen   = 0;
    int  ops_sent       = 0;
    int  full_refusals  = 0;
    int  empty_refusals = 0;
    int  clears_sent    = 0;
    int  quiet_cycles   = 0;
    bit  stall_enable   = 1'b1;

    double_ended_queue dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .push_value   (push_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .popped_value (popped_value),
        .front_value  (front_value),
        .rear_value   (rear_value),
        .occupancy    (occupancy),
        .full_flag    (full_flag),
        .empty_flag   (empty_flag),
        .op_status    (op_status)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic deque_view_t predict_deque_op(input logic [2:0] op,
                                                     input logic [DATA_W-1:0] val);
        deque_view_t v;
        v.popped = '0;
        v.front  = '0;
        v.rear   = '0;
        v.status = ST_DONE;
        case (op)
            OP_PUSH_FRONT:
                if (shadow_count == CAPACITY)
                    v.status = ST_PUSH_REJECT;
                else
                begin
                    shadow_head = (shadow_head + CAPACITY - 1) % CAPACITY;
                    shadow_store[shadow_head] = val;
                    shadow_count++;
                end
            OP_PUSH_REAR:
                if (shadow_count == CAPACITY)
                    v.status = ST_PUSH_REJECT;
                else
                begin
                    shadow_store[(shadow_head + shadow_count) % CAPACITY] = val;
                    shadow_count++;
                end
            OP_POP_FRONT:
                if (shadow_count == 0)
                    v.status = ST_POP_REJECT;
                else
                begin
                    v.popped = shadow_store[shadow_head];
                    shadow_head = (shadow_head + 1) % CAPACITY;
                    shadow_count--;
                end
            OP_POP_REAR:
                if (shadow_count == 0)
                    v.status = ST_POP_REJECT;
                else
                begin
                    v.popped = shadow_store[(shadow_head + shadow_count - 1) % CAPACITY];
                    shadow_count--;
                end
            OP_CLEAR:
            begin
                shadow_head  = 0;
                shadow_count = 0;
            end
            default: ;
        endcase
        if (shadow_count != 0)
        begin
            v.front = shadow_store[shadow_head];
            v.rear  = shadow_store[(shadow_head + shadow_count - 1) % CAPACITY];
        end
        v.count = CNT_W'(shadow_count);
        v.full  = (shadow_count == CAPACITY);
        v.empty = (shadow_count == 0);
        return v;
    endfunction

    task automatic report_mismatch(input string field, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("%0t: mismatch on %s: got %0h, expected %0h", $time, field, got, want);
    endtask

    // called at a clock edge; leaves valid high so a following transaction can go back to back
    task automatic send_op(input logic [2:0] op, input logic [DATA_W-1:0] val);
        deque_view_t v;
        in_valid   <= 1'b1;
        opcode     <= op;
        push_value <= val;
        do
            @(posedge clk);
        while (!in_ready);
        v = predict_deque_op(op, val);
        pending_views.push_back(v);
        ops_sent++;
        if (v.status == ST_PUSH_REJECT)
            full_refusals++;
        if (v.status == ST_POP_REJECT)
            empty_refusals++;
        if (op == OP_CLEAR)
            clears_sent++;
    endtask

    task automatic hold_off(input int cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic wait_for_drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_views.size() != 0);
    endtask

    // result checker
    always @(posedge clk)
    begin
        deque_view_t want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
        begin
            results_seen++;
            if (pending_views.size() == 0)
                report_mismatch("unexpected transaction", '0, '0);
            else
            begin
                want = pending_views.pop_front();
                if (popped_value !== want.popped)
                    report_mismatch("popped_value", popped_value, want.popped);
                if (front_value !== want.front)
                    report_mismatch("front_value", front_value, want.front);
                if (rear_value !== want.rear)
                    report_mismatch("rear_value", rear_value, want.rear);
                if (occupancy !== want.count)
                    report_mismatch("occupancy", DATA_W'(occupancy), DATA_W'(want.count));
                if (full_flag !== want.full)
                    report_mismatch("full_flag", DATA_W'(full_flag), DATA_W'(want.full));
                if (empty_flag !== want.empty)
                    report_mismatch("empty_flag", DATA_W'(empty_flag), DATA_W'(want.empty));
                if (op_status !== want.status)
                    report_mismatch("op_status", DATA_W'(op_status), DATA_W'(want.status));
            end
        end
    end

    // watchdog: ends the run if no transaction moves for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // receiver back-pressure in random bursts
    initial
    begin
        forever
        begin
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            if (stall_enable)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
    end

    task automatic test_empty_rejects();
        send_op(OP_POP_FRONT, 8'h5A);
        send_op(OP_POP_REAR, 8'hA5);
        send_op(OP_CLEAR, 8'hFF);
    endtask

    // alternating ends, so the head wraps below index zero right away
    task automatic test_fill_and_overflow();
        logic [DATA_W-1:0] val;
        for (int i = 0; i < CAPACITY; i++)
        begin
            val = (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : DATA_W'($urandom_range(0, 255));
            send_op((i % 2 == 0) ? OP_PUSH_FRONT : OP_PUSH_REAR, val);
        end
        send_op(OP_PUSH_FRONT, 8'h11);
        send_op(OP_PUSH_REAR, 8'h22);
    endtask

    task automatic test_pop_and_clear();
        send_op(OP_POP_FRONT, 8'h00);
        send_op(OP_POP_REAR, 8'h00);
        send_op(OP_CLEAR, 8'h00);
        send_op(OP_POP_FRONT, 8'hFF);
    endtask

    // random walk that swings between filling and draining so both limits get hit
    task automatic test_random_traffic(input int n_items, input bit with_gaps);
        logic [2:0] op;
        int push_weight = 68;
        int phase_left  = 0;
        int pick;
        bit gap_stretch = 1'b1;
        for (int i = 0; i < n_items; i++)
        begin
            if (phase_left == 0)
            begin
                push_weight = (push_weight > 50) ? 28 : 68;
                phase_left  = $urandom_range(10, 40);
            end
            phase_left--;
            if (i % 32 == 0)
                gap_stretch = $urandom_range(0, 1);
            if (with_gaps && i > 0 && i % 250 == 0)
                wait_for_drain();
            else if (with_gaps && gap_stretch && $urandom_range(0, 3) == 0)
                hold_off($urandom_range(1, 8));
            pick = $urandom_range(0, 99);
            if (pick < 2)
                op = OP_CLEAR;
            else if (pick < 2 + push_weight)
                op = $urandom_range(0, 1) ? OP_PUSH_REAR : OP_PUSH_FRONT;
            else
                op = $urandom_range(0, 1) ? OP_POP_REAR : OP_POP_FRONT;
            send_op(op, DATA_W'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        opcode     <= OP_CLEAR;
        push_value <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_rejects();
        test_fill_and_overflow();
        test_pop_and_clear();
        test_random_traffic(800, 1'b1);
        stall_enable = 1'b0;
        test_random_traffic(300, 1'b0);

        in_valid <= 1'b0;
        while (pending_views.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        $display("covered %0d operations: %0d pushes refused at full, %0d pops refused at empty",
                 ops_sent, full_refusals, empty_refusals);
        $display("%0d clears; checked %0d results, %0d field mismatches",
                 clears_sent, results_seen, mismatch_count);
        if (mismatch_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
